// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the deframer RTL.
// Clocked property checks with a synchronous reset as the disable term.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge out of reset.
`define ASSERT_AT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Expression must never be true at a rising clock edge out of reset.
`define ASSERT_NEVER(name, clk, rst, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ===== rtl/lprd_pkg.sv =====
// Shared types, constants and helpers for the length-prefixed record deframer.
// No dependencies; used by every module of the block.
package lprd_pkg;

  localparam int LENGTH_BITS_DEF = 28;
  localparam int LIMIT_W         = 28;
  localparam int MAGIC_LENGTH    = 4;
  localparam int CNT_W           = $clog2(MAGIC_LENGTH + 1);
  localparam int IDX_W           = (MAGIC_LENGTH > 1) ? $clog2(MAGIC_LENGTH) : 1;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(65536);

  localparam logic [7:0] MAGIC_BYTES [8] = '{8'o002, 8'o014, 8'o017, 8'o013,
                                             8'h00, 8'h00, 8'h00, 8'h00};

  typedef enum logic [2:0] {
    ST_PAYLOAD    = 3'd0,
    ST_RAW        = 3'd1,
    ST_EMPTY      = 3'd2,
    ST_END        = 3'd3,
    ST_PAST_END   = 3'd4,
    ST_NOT_RECORD = 3'd5,
    ST_TRUNCATED  = 3'd6
  } status_t;

  typedef struct packed {
    logic [7:0] out_byte;
    status_t    status;
    logic       record_last;
    logic       over_limit;
  } result_t;

  typedef struct packed {
    result_t [MAGIC_LENGTH-1:0] items;
    logic [CNT_W-1:0]           count;
  } bundle_t;

  typedef struct packed {
    logic               force_record_mode;
    logic [LIMIT_W-1:0] record_limit;
  } cfg_t;

  function automatic result_t mk_result(logic [7:0] b, status_t s, logic last, logic ov);
    result_t r;
    r.out_byte    = b;
    r.status      = s;
    r.record_last = last;
    r.over_limit  = ov;
    return r;
  endfunction

endpackage

// ===== rtl/lprd_regs.sv =====
// APB configuration registers of the deframer: force_record_mode, record_limit.
// Depends on lprd_pkg.
module lprd_regs (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output lprd_pkg::cfg_t   cfg
);
  import lprd_pkg::*;

  localparam logic REG_FORCE = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.force_record_mode <= 1'b0;
      cfg.record_limit      <= LIMIT_RESET;
    end else if (wr) begin
      unique case (paddr[2])
        REG_FORCE: cfg.force_record_mode <= pwdata[0];
        REG_LIMIT: cfg.record_limit      <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FORCE: prdata = {31'd0, cfg.force_record_mode};
      REG_LIMIT: prdata = 32'(cfg.record_limit);
      default:   prdata = '0;
    endcase
  end

endmodule

// ===== rtl/lprd_out_buf.sv =====
// Result bundle buffer and output register of the deframer. Depends on lprd_pkg.
// Drains up to MAGIC_LENGTH results per request, one per cycle if m_tready is high.
`include "assert_macros.svh"
module lprd_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  lprd_pkg::bundle_t bundle,
  output logic              in_ready,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,   // out_byte
  output logic [3:0]        m_tuser,   // [2:0] status, [3] over_limit
  output logic              m_tlast    // record_last
);
  import lprd_pkg::*;

  result_t [MAGIC_LENGTH-1:0] items;
  logic [CNT_W-1:0]           rem;
  logic [IDX_W-1:0]           ptr;
  result_t                    out_res;
  logic                       out_valid;
  logic                       pop;

  assign pop      = (rem != '0) && (!out_valid || m_tready);
  assign in_ready = (rem == '0) || ((rem == CNT_W'(1)) && pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      rem       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        items <= bundle.items;
        rem   <= bundle.count;
        ptr   <= '0;
      end else if (pop) begin
        rem <= rem - CNT_W'(1);
        ptr <= ptr + IDX_W'(1);
      end
      if (pop) begin
        out_res   <= items[ptr];
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_res.out_byte;
  assign m_tuser  = {out_res.over_limit, out_res.status};
  assign m_tlast  = out_res.record_last;

  `ASSERT_NEVER(a_load_busy, clk, rst, load && (rem > CNT_W'(1) || (rem == CNT_W'(1) && !pop)), "bundle overwritten before drained")
  `ASSERT_NEVER(a_rem_range, clk, rst, rem > CNT_W'(MAGIC_LENGTH), "bundle count out of range")

endmodule

// ===== rtl/length_prefixed_record_deframer_unit.sv =====
// Length-prefixed record deframer, top level.
// Holds the parse state machine; uses lprd_regs, lprd_out_buf and lprd_pkg.
//
// Input stream (s_*): one request per byte; s_tuser high marks end of input
// instead of a byte. Output stream (m_*): zero to four results per request, m_tdata the
// byte, m_tuser the status and over-limit flag, m_tlast the last payload byte.
// The first four bytes are checked against the magic header; on a match the
// stream is parsed as records (7-bit big-endian length digits, then payload),
// otherwise the stream fails (forced mode) or is passed through raw.
// Each result is registered in the bundle buffer, then in the output register.
// Throughput: one input request per cycle while m_tready is high; a header
// mismatch or an early end releases up to four results from one request, which
// drain one per cycle, while m_tready is high, with s_tready low. The state update
// is one pass of logic between the state registers and the result bundle register.
// Reset: synchronous rst clears the parser to header detection and loads the
// register defaults (auto-detect, limit 65536). When m_tready is low the
// output register holds its result; a request is taken into the bundle stage
// only while it is empty. Write the APB registers only while idle.
`include "assert_macros.svh"
module length_prefixed_record_deframer_unit #(
  parameter int LENGTH_BITS = lprd_pkg::LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // in_byte
  input  logic        s_tuser,   // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // out_byte
  output logic [3:0]  m_tuser,   // [2:0] status, [3] over_limit
  output logic        m_tlast,   // record_last
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lprd_pkg::*;

  localparam int CMP_W = (LENGTH_BITS > LIMIT_W) ? LENGTH_BITS : LIMIT_W;

  typedef enum logic [2:0] {
    PH_HEADER, PH_RAW, PH_IDLE, PH_LENGTH, PH_PAYLOAD, PH_FAILED
  } phase_t;

  cfg_t                   cfg;
  bundle_t                bundle;
  logic                   accept;

  phase_t                 phase, phase_next;
  logic [7:0]             held [MAGIC_LENGTH];
  logic [7:0]             held_next [MAGIC_LENGTH];
  logic [IDX_W-1:0]       held_count, held_count_next;
  logic [LENGTH_BITS-1:0] length_accum, length_accum_next;
  logic [LENGTH_BITS-1:0] bytes_left, bytes_left_next;
  logic                   end_seen, end_seen_next;
  logic                   limit_exceeded, limit_exceeded_next;

  logic                   magic_match;
  logic                   at_decision;
  logic                   acc_sat;
  logic [LENGTH_BITS+6:0] acc_shifted;
  logic [LENGTH_BITS-1:0] acc_new;

  lprd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lprd_out_buf u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .bundle   (bundle),
    .in_ready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  assign accept = s_tvalid & s_tready;

  always_comb begin
    magic_match = (s_tdata == MAGIC_BYTES[MAGIC_LENGTH-1]);
    for (int i = 0; i < MAGIC_LENGTH - 1; i++) begin
      if (held[i] != MAGIC_BYTES[i]) magic_match = 1'b0;
    end
  end

  assign at_decision = (held_count == IDX_W'(MAGIC_LENGTH - 1));
  assign acc_sat     = |(length_accum >> (LENGTH_BITS - 7));
  assign acc_shifted = {length_accum, s_tdata[6:0]};
  assign acc_new     = acc_sat ? '1 : acc_shifted[LENGTH_BITS-1:0];

  always_comb begin
    phase_next          = phase;
    held_next           = held;
    held_count_next     = held_count;
    length_accum_next   = length_accum;
    bytes_left_next     = bytes_left;
    end_seen_next       = end_seen;
    limit_exceeded_next = limit_exceeded;
    bundle              = '0;
    if (accept) begin
      unique case (phase)
        PH_HEADER: begin
          if (s_tuser) begin
            if (cfg.force_record_mode) begin
              phase_next      = PH_FAILED;
              bundle.items[0] = mk_result(8'd0, ST_NOT_RECORD, 1'b0, 1'b0);
              bundle.count    = CNT_W'(1);
            end else begin
              for (int i = 0; i < MAGIC_LENGTH; i++) begin
                if (i < int'(held_count)) begin
                  bundle.items[i] = mk_result(held[i], ST_RAW, 1'b0, 1'b0);
                end else if (i == int'(held_count)) begin
                  bundle.items[i] = mk_result(8'd0, ST_END, 1'b0, 1'b0);
                end
              end
              bundle.count    = CNT_W'(held_count) + CNT_W'(1);
              held_count_next = '0;
              phase_next      = PH_RAW;
              end_seen_next   = 1'b1;
            end
          end else if (!at_decision) begin
            held_next[held_count] = s_tdata;
            held_count_next       = held_count + IDX_W'(1);
          end else begin
            held_count_next = '0;
            if (magic_match) begin
              phase_next = PH_IDLE;
            end else if (cfg.force_record_mode) begin
              phase_next      = PH_FAILED;
              bundle.items[0] = mk_result(8'd0, ST_NOT_RECORD, 1'b0, 1'b0);
              bundle.count    = CNT_W'(1);
            end else begin
              for (int i = 0; i < MAGIC_LENGTH - 1; i++) begin
                bundle.items[i] = mk_result(held[i], ST_RAW, 1'b0, 1'b0);
              end
              bundle.items[MAGIC_LENGTH-1] = mk_result(s_tdata, ST_RAW, 1'b0, 1'b0);
              bundle.count = CNT_W'(MAGIC_LENGTH);
              phase_next   = PH_RAW;
            end
          end
        end
        PH_RAW: begin
          bundle.count = CNT_W'(1);
          if (s_tuser) begin
            bundle.items[0] = mk_result(8'd0, end_seen ? ST_PAST_END : ST_END, 1'b0, 1'b0);
            end_seen_next   = 1'b1;
          end else begin
            bundle.items[0] = mk_result(s_tdata, ST_RAW, 1'b0, 1'b0);
          end
        end
        PH_IDLE, PH_LENGTH: begin
          if (s_tuser) begin
            bundle.count  = CNT_W'(1);
            end_seen_next = 1'b1;
            if (phase == PH_IDLE) begin
              bundle.items[0] = mk_result(8'd0, end_seen ? ST_PAST_END : ST_END, 1'b0, 1'b0);
            end else begin
              bundle.items[0]   = mk_result(8'd0, ST_TRUNCATED, 1'b0, 1'b0);
              phase_next        = PH_IDLE;
              length_accum_next = '0;
            end
          end else if (s_tdata[7]) begin
            length_accum_next = acc_new;
            phase_next        = PH_LENGTH;
          end else if (acc_new == '0) begin
            length_accum_next = '0;
            phase_next        = PH_IDLE;
            bundle.items[0]   = mk_result(8'd0, ST_EMPTY, 1'b0, 1'b0);
            bundle.count      = CNT_W'(1);
          end else begin
            bytes_left_next     = acc_new;
            limit_exceeded_next = CMP_W'(acc_new) > CMP_W'(cfg.record_limit);
            length_accum_next   = '0;
            phase_next          = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          bundle.count = CNT_W'(1);
          if (s_tuser) begin
            bundle.items[0]     = mk_result(8'd0, ST_TRUNCATED, 1'b0, limit_exceeded);
            phase_next          = PH_IDLE;
            bytes_left_next     = '0;
            limit_exceeded_next = 1'b0;
            end_seen_next       = 1'b1;
          end else begin
            bundle.items[0] = mk_result(s_tdata, ST_PAYLOAD,
                                        bytes_left == LENGTH_BITS'(1), limit_exceeded);
            bytes_left_next = bytes_left - LENGTH_BITS'(1);
            if (bytes_left == LENGTH_BITS'(1)) begin
              phase_next          = PH_IDLE;
              limit_exceeded_next = 1'b0;
            end
          end
        end
        default: begin
          phase_next      = PH_FAILED;
          bundle.items[0] = mk_result(8'd0, ST_NOT_RECORD, 1'b0, 1'b0);
          bundle.count    = CNT_W'(1);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      held_count     <= '0;
      length_accum   <= '0;
      bytes_left     <= '0;
      end_seen       <= 1'b0;
      limit_exceeded <= 1'b0;
    end else begin
      phase          <= phase_next;
      held           <= held_next;
      held_count     <= held_count_next;
      length_accum   <= length_accum_next;
      bytes_left     <= bytes_left_next;
      end_seen       <= end_seen_next;
      limit_exceeded <= limit_exceeded_next;
    end
  end

  `ASSERT_AT(a_payload_left, clk, rst, phase == PH_PAYLOAD |-> bytes_left != '0, "payload phase with no bytes left")
  `ASSERT_AT(a_failed_sticky, clk, rst, phase == PH_FAILED |=> phase == PH_FAILED, "left failed state")
  `ASSERT_AT(a_limit_in_payload, clk, rst, limit_exceeded |-> phase == PH_PAYLOAD, "over-limit flag outside a record")

endmodule
